// ===== hw/rtl/fara_pkg.sv =====
// Shared types and codes for the fraction add-and-reduce unit.
`timescale 1ns / 1ps

package fara_pkg;

   // Output field widths
   localparam int WHOLE_W = 33;
   localparam int REST_W  = 32;
   localparam int RDEN_W  = 32;

   // Result form codes
   localparam logic [1:0] FORM_INT    = 2'd0;
   localparam logic [1:0] FORM_PROPER = 2'd1;
   localparam logic [1:0] FORM_MIXED  = 2'd2;

   // Which fraction a result describes
   localparam logic [1:0] WHICH_A   = 2'd0;
   localparam logic [1:0] WHICH_B   = 2'd1;
   localparam logic [1:0] WHICH_SUM = 2'd2;

   // Kind of result the controller asks the datapath to build
   localparam logic [1:0] KIND_ZERO = 2'd0;
   localparam logic [1:0] KIND_INT  = 2'd1;
   localparam logic [1:0] KIND_FRAC = 2'd2;

   // Multiplier operand selects
   localparam logic [1:0] MUL_SEL_DEN = 2'd0;
   localparam logic [1:0] MUL_SEL_N1  = 2'd1;
   localparam logic [1:0] MUL_SEL_N2  = 2'd2;

   // Divider operand selects
   localparam logic [1:0] DIV_SEL_QUOT = 2'd0;
   localparam logic [1:0] DIV_SEL_GCD  = 2'd1;
   localparam logic [1:0] DIV_SEL_REST = 2'd2;
   localparam logic [1:0] DIV_SEL_RDEN = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic       ops_load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       sden_load;
      logic       snum_load;
      logic       snum_add;
      logic       frac_load;
      logic [1:0] which;
      logic       div_start;
      logic [1:0] div_sel;
      logic       cap_first;
      logic       cap_gcd;
      logic       cap_rest;
      logic       cap_rden;
      logic       rsp_load;
      logic [1:0] rsp_kind;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic den_zero;
      logic div_done;
      logic div_rem_zero;
   } status_type;

endpackage

// ===== hw/rtl/fara_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fara_divider #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder,
   output logic             done
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   // One shift-subtract step
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== hw/rtl/fara_datapath.sv =====
// Datapath: operand registers, shared multiplier, divider and result register.
`timescale 1ns / 1ps

module fara_datapath
   import fara_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [OPERAND_WIDTH-1:0] req_num_a,
   input  logic [OPERAND_WIDTH-1:0] req_den_a,
   input  logic [OPERAND_WIDTH-1:0] req_num_b,
   input  logic [OPERAND_WIDTH-1:0] req_den_b,
   output logic [1:0]               rsp_which_fraction,
   output logic [1:0]               rsp_form,
   output logic [WHOLE_W-1:0]       rsp_whole_part,
   output logic [REST_W-1:0]        rsp_rest_numerator,
   output logic [RDEN_W-1:0]        rsp_reduced_denominator,
   output logic                     rsp_last
);

   localparam int W  = OPERAND_WIDTH;
   // Sum width: one bit over the product width, capped at 64 bits
   localparam int VW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;

   logic [W-1:0]    na_ff, da_ff, nb_ff, db_ff;
   logic [2*W-1:0]  mul_ff;
   logic [W-1:0]    mul_a, mul_b;
   logic [VW-1:0]   sden_ff, snum_ff;
   logic [VW-1:0]   num_ff, den_ff;
   logic [VW-1:0]   x_ff, y_ff;
   logic [VW-1:0]   r_ff;
   logic [VW-1:0]   whole_ff, rest_ff, rden_ff;
   logic [VW-1:0]   div_dividend, div_divisor;
   logic [VW-1:0]   div_quo, div_rem;
   logic            div_done;
   logic [63:0]     whole64, rest64, rden64;

   // Operand capture on input transfer
   always_ff @(posedge clock) begin
      if (cmd.ops_load) begin
         na_ff <= req_num_a;
         da_ff <= req_den_a;
         nb_ff <= req_num_b;
         db_ff <= req_den_b;
      end
   end

   // Shared multiplier, registered product
   always_comb begin
      case (cmd.mul_sel)
         MUL_SEL_DEN: begin mul_a = da_ff; mul_b = db_ff; end
         MUL_SEL_N1:  begin mul_a = na_ff; mul_b = db_ff; end
         MUL_SEL_N2:  begin mul_a = nb_ff; mul_b = da_ff; end
         default:     begin mul_a = da_ff; mul_b = db_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mul_ff <= mul_a * mul_b;
      end
   end

   // Sum numerator and denominator
   always_ff @(posedge clock) begin
      if (cmd.sden_load) begin
         sden_ff <= VW'(mul_ff);
      end
      if (cmd.snum_load) begin
         snum_ff <= VW'(mul_ff);
      end else if (cmd.snum_add) begin
         snum_ff <= snum_ff + VW'(mul_ff);
      end
   end

   // Fraction under work
   always_ff @(posedge clock) begin
      if (cmd.frac_load) begin
         case (cmd.which)
            WHICH_A: begin num_ff <= VW'(na_ff); den_ff <= VW'(da_ff); end
            WHICH_B: begin num_ff <= VW'(nb_ff); den_ff <= VW'(db_ff); end
            default: begin num_ff <= snum_ff;    den_ff <= sden_ff;    end
         endcase
      end
   end

   // Divider operand select; x holds the GCD once the loop ends
   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_QUOT: begin div_dividend = num_ff; div_divisor = den_ff; end
         DIV_SEL_GCD:  begin div_dividend = x_ff;   div_divisor = y_ff;   end
         DIV_SEL_REST: begin div_dividend = r_ff;   div_divisor = x_ff;   end
         default:      begin div_dividend = den_ff; div_divisor = x_ff;   end
      endcase
   end

   fara_divider #(
      .WIDTH (VW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // Capture divider results; GCD runs on (den, num mod den)
   always_ff @(posedge clock) begin
      if (cmd.cap_first) begin
         whole_ff <= div_quo;
         r_ff     <= div_rem;
         x_ff     <= den_ff;
         y_ff     <= div_rem;
      end else if (cmd.cap_gcd) begin
         x_ff <= y_ff;
         y_ff <= div_rem;
      end
      if (cmd.cap_rest) begin
         rest_ff <= div_quo;
      end
      if (cmd.cap_rden) begin
         rden_ff <= div_quo;
      end
   end

   assign whole64 = 64'(whole_ff);
   assign rest64  = 64'(rest_ff);
   assign rden64  = 64'(rden_ff);

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_which_fraction <= cmd.which;
         rsp_last           <= (cmd.which == WHICH_SUM);
         case (cmd.rsp_kind)
            KIND_INT: begin
               rsp_form                <= FORM_INT;
               rsp_whole_part          <= whole64[WHOLE_W-1:0];
               rsp_rest_numerator      <= '0;
               rsp_reduced_denominator <= RDEN_W'(1);
            end
            KIND_FRAC: begin
               rsp_form                <= (whole_ff == '0) ? FORM_PROPER : FORM_MIXED;
               rsp_whole_part          <= whole64[WHOLE_W-1:0];
               rsp_rest_numerator      <= rest64[REST_W-1:0];
               rsp_reduced_denominator <= rden64[RDEN_W-1:0];
            end
            default: begin
               rsp_form                <= FORM_INT;
               rsp_whole_part          <= '0;
               rsp_rest_numerator      <= '0;
               rsp_reduced_denominator <= '0;
            end
         endcase
      end
   end

   assign status.den_zero     = (den_ff == '0);
   assign status.div_done     = div_done;
   assign status.div_rem_zero = (div_rem == '0);

endmodule

// ===== hw/rtl/fara_controller.sv =====
// Controller state machine sequencing multiply, divide and GCD steps.
`timescale 1ns / 1ps

module fara_controller
   import fara_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_MUL0      = 5'd1;
   localparam logic [4:0] ST_MUL1      = 5'd2;
   localparam logic [4:0] ST_MUL2      = 5'd3;
   localparam logic [4:0] ST_MUL3      = 5'd4;
   localparam logic [4:0] ST_LOAD      = 5'd5;
   localparam logic [4:0] ST_CHECK     = 5'd6;
   localparam logic [4:0] ST_DIVQ_GO   = 5'd7;
   localparam logic [4:0] ST_DIVQ_WAIT = 5'd8;
   localparam logic [4:0] ST_GCD_GO    = 5'd9;
   localparam logic [4:0] ST_GCD_WAIT  = 5'd10;
   localparam logic [4:0] ST_DIVR_GO   = 5'd11;
   localparam logic [4:0] ST_DIVR_WAIT = 5'd12;
   localparam logic [4:0] ST_DIVD_GO   = 5'd13;
   localparam logic [4:0] ST_DIVD_WAIT = 5'd14;
   localparam logic [4:0] ST_EMIT      = 5'd15;
   localparam logic [4:0] ST_HOLD      = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [1:0] which_ff, which_in;
   logic [1:0] kind_ff, kind_in;

   always_comb begin
      state_in = state_ff;
      which_in = which_ff;
      kind_in  = kind_ff;
      cmd          = '0;
      cmd.which    = which_ff;
      cmd.rsp_kind = kind_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.ops_load = 1'b1;
               state_in     = ST_MUL0;
            end
         end
         // Sum denominator, then the two cross products
         ST_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_DEN;
            state_in    = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.sden_load = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_SEL_N1;
            state_in      = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.snum_load = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_SEL_N2;
            state_in      = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.snum_add = 1'b1;
            which_in     = WHICH_A;
            state_in     = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.frac_load = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.den_zero) begin
               kind_in  = KIND_ZERO;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIVQ_GO;
            end
         end
         // Integer quotient and remainder
         ST_DIVQ_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_QUOT;
            state_in      = ST_DIVQ_WAIT;
         end
         ST_DIVQ_WAIT: begin
            if (status.div_done) begin
               cmd.cap_first = 1'b1;
               if (status.div_rem_zero) begin
                  kind_in  = KIND_INT;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_GCD_GO;
               end
            end
         end
         // Euclid loop
         ST_GCD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_GCD;
            state_in      = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (status.div_done) begin
               cmd.cap_gcd = 1'b1;
               state_in    = status.div_rem_zero ? ST_DIVR_GO : ST_GCD_GO;
            end
         end
         // Reduce remainder and denominator by the GCD
         ST_DIVR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_REST;
            state_in      = ST_DIVR_WAIT;
         end
         ST_DIVR_WAIT: begin
            if (status.div_done) begin
               cmd.cap_rest = 1'b1;
               state_in     = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_RDEN;
            state_in      = ST_DIVD_WAIT;
         end
         ST_DIVD_WAIT: begin
            if (status.div_done) begin
               cmd.cap_rden = 1'b1;
               kind_in      = KIND_FRAC;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_HOLD;
         end
         // Result waits for transfer, then next fraction
         ST_HOLD: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (which_ff == WHICH_SUM) begin
                  state_in = ST_IDLE;
               end else begin
                  which_in = which_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         which_ff <= WHICH_A;
         kind_ff  <= KIND_ZERO;
      end else begin
         state_ff <= state_in;
         which_ff <= which_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ===== hw/rtl/fraction_add_and_reduce_unit.sv =====
// Sequence: the multiplier forms the sum terms, then each fraction (A, B, sum) goes through D divisions on
// the V-bit divider, V = min(2*OPERAND_WIDTH+1, 64), with D = 1 when the fraction is an integer, else 3
// plus the Euclid step count; zero denominators skip division. Each result then waits for the output.
// Throughput: one item at a time, set by the single bit-serial divider (one quotient bit a cycle).
// Reset (synchronous, active high) returns the controller to idle; no result is pending after it.
`timescale 1ns / 1ps

module fraction_add_and_reduce_unit
   import fara_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPERAND_WIDTH-1:0] req_num_a,
   input  logic [OPERAND_WIDTH-1:0] req_den_a,
   input  logic [OPERAND_WIDTH-1:0] req_num_b,
   input  logic [OPERAND_WIDTH-1:0] req_den_b,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_which_fraction,
   output logic [1:0]               rsp_form,
   output logic [WHOLE_W-1:0]       rsp_whole_part,
   output logic [REST_W-1:0]        rsp_rest_numerator,
   output logic [RDEN_W-1:0]        rsp_reduced_denominator,
   output logic                     rsp_last
);

   cmd_type    cmd;
   status_type status;

   fara_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fara_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_num_a               (req_num_a),
      .req_den_a               (req_den_a),
      .req_num_b               (req_num_b),
      .req_den_b               (req_den_b),
      .rsp_which_fraction      (rsp_which_fraction),
      .rsp_form                (rsp_form),
      .rsp_whole_part          (rsp_whole_part),
      .rsp_rest_numerator      (rsp_rest_numerator),
      .rsp_reduced_denominator (rsp_reduced_denominator),
      .rsp_last                (rsp_last)
   );

endmodule

// ===== hw/rtl/fara_checker.sv =====
// Port-level checks for the fraction add-and-reduce unit, bound to the top level.
`timescale 1ns / 1ps

module fara_checker
   import fara_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [OPERAND_WIDTH-1:0] req_num_a,
   input logic [OPERAND_WIDTH-1:0] req_den_a,
   input logic [OPERAND_WIDTH-1:0] req_num_b,
   input logic [OPERAND_WIDTH-1:0] req_den_b,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_which_fraction,
   input logic [1:0]               rsp_form,
   input logic [WHOLE_W-1:0]       rsp_whole_part,
   input logic [REST_W-1:0]        rsp_rest_numerator,
   input logic [RDEN_W-1:0]        rsp_reduced_denominator,
   input logic                     rsp_last
);

   // A stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_whole_part)
         && $stable(rsp_rest_numerator) && $stable(rsp_reduced_denominator))
      else $error("stalled result changed");

   // Only the sum result carries the last mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_which_fraction == WHICH_SUM)))
      else $error("last mark not on sum result");

   // Integer results carry no remainder
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_form == FORM_INT |-> rsp_rest_numerator == '0)
      else $error("integer result with remainder");

   // Proper fractions have no whole part and a nonzero remainder
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_form == FORM_PROPER |->
         rsp_whole_part == '0 && rsp_rest_numerator != '0)
      else $error("malformed proper fraction");

   // One item in flight: no transfer in the cycle after an input transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("input taken while busy");

endmodule

bind fraction_add_and_reduce_unit fara_checker #(
   .OPERAND_WIDTH (OPERAND_WIDTH)
) u_fara_checker (.*);

// ===== test/tb_fraction_add_and_reduce_unit.sv =====
// Self-checking testbench for the fraction add-and-reduce unit: directed and random pairs.
`timescale 1ns / 1ps

module tb_fraction_add_and_reduce_unit;
   import fara_pkg::*;

   localparam int OPERAND_W   = 16;
   localparam int RANDOM_ITEMS = 131;
   // Receiver hold-off long enough for the unit to park a result and refuse input.
   localparam int LONG_HOLD   = 1500;
   // Slowest item: three fractions of up to 50 divisions each, plus output stalls;
   // with the long hold-off on top this limit leaves ample margin.
   localparam int STALL_LIMIT = 40000;
   localparam int TAIL_CYCLES = 300;

   typedef struct packed {
      logic [1:0]         which_fraction;
      logic [1:0]         form;
      logic [WHOLE_W-1:0] whole_part;
      logic [REST_W-1:0]  rest_numerator;
      logic [RDEN_W-1:0]  reduced_denominator;
      logic               last;
   } fraction_result_type;

   // Expected results per accepted pair, and the check of each result transfer
   class fraction_sum_checker;
      fraction_result_type expected_fractions[$];
      int mismatches = 0;
      int results_checked = 0;
      int pairs_noted = 0;

      function bit [63:0] common_divisor(bit [63:0] x, bit [63:0] y);
         bit [63:0] r;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         return x;
      endfunction

      // Integer, proper or mixed form of num/den after GCD reduction
      function fraction_result_type reduce_fraction(logic [1:0] which, bit [63:0] num,
                                                    bit [63:0] den, logic is_sum);
         fraction_result_type r;
         bit [63:0] g, n, d, whole, rest;
         r.which_fraction      = which;
         r.last                = is_sum;
         r.form                = FORM_INT;
         r.whole_part          = '0;
         r.rest_numerator      = '0;
         r.reduced_denominator = '0;
         // zero denominator leaves everything zero
         if (den != 0) begin
            if (num % den == 0) begin
               whole                 = num / den;
               r.whole_part          = whole[WHOLE_W-1:0];
               r.reduced_denominator = RDEN_W'(1);
            end else begin
               g     = common_divisor(num, den);
               n     = num / g;
               d     = den / g;
               whole = n / d;
               rest  = n - whole * d;
               r.whole_part          = whole[WHOLE_W-1:0];
               r.rest_numerator      = rest[REST_W-1:0];
               r.reduced_denominator = d[RDEN_W-1:0];
               r.form                = (num < den) ? FORM_PROPER : FORM_MIXED;
            end
         end
         return r;
      endfunction

      function void note_request(bit [OPERAND_W-1:0] na, bit [OPERAND_W-1:0] da,
                                 bit [OPERAND_W-1:0] nb, bit [OPERAND_W-1:0] db);
         bit [63:0] a_num, a_den, b_num, b_den, sum_num, sum_den;
         a_num   = na;
         a_den   = da;
         b_num   = nb;
         b_den   = db;
         sum_den = a_den * b_den;
         sum_num = a_num * b_den + b_num * a_den;
         expected_fractions.push_back(reduce_fraction(WHICH_A, a_num, a_den, 1'b0));
         expected_fractions.push_back(reduce_fraction(WHICH_B, b_num, b_den, 1'b0));
         expected_fractions.push_back(reduce_fraction(WHICH_SUM, sum_num, sum_den, 1'b1));
         pairs_noted++;
      endfunction

      // Field listing for messages
      function string describe(fraction_result_type r);
         return $sformatf("which=%0d form=%0d whole=%0d rest=%0d den=%0d last=%0d",
                          r.which_fraction, r.form, r.whole_part, r.rest_numerator,
                          r.reduced_denominator, r.last);
      endfunction

      function void check_result(fraction_result_type got);
         fraction_result_type want;
         if (expected_fractions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected result: %s", $time, describe(got));
            return;
         end
         want = expected_fractions.pop_front();
         results_checked++;
         if (got.which_fraction !== want.which_fraction || got.form !== want.form ||
             got.whole_part !== want.whole_part ||
             got.rest_numerator !== want.rest_numerator ||
             got.reduced_denominator !== want.reduced_denominator ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] mismatch expected: %s", $time, describe(want));
               $display("[%0t] mismatch actual:   %s", $time, describe(got));
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OPERAND_W-1:0] req_num_a = '0;
   logic [OPERAND_W-1:0] req_den_a = '0;
   logic [OPERAND_W-1:0] req_num_b = '0;
   logic [OPERAND_W-1:0] req_den_b = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_which_fraction;
   logic [1:0]           rsp_form;
   logic [WHOLE_W-1:0]   rsp_whole_part;
   logic [REST_W-1:0]    rsp_rest_numerator;
   logic [RDEN_W-1:0]    rsp_reduced_denominator;
   logic                 rsp_last;

   fraction_sum_checker checker_h;

   // idling controls, set by the stimulus sequence
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_requested = 1'b0;

   fraction_add_and_reduce_unit #(
      .OPERAND_WIDTH(OPERAND_W)
   ) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_num_a              (req_num_a),
      .req_den_a              (req_den_a),
      .req_num_b              (req_num_b),
      .req_den_b              (req_den_b),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_which_fraction     (rsp_which_fraction),
      .rsp_form               (rsp_form),
      .rsp_whole_part         (rsp_whole_part),
      .rsp_rest_numerator     (rsp_rest_numerator),
      .rsp_reduced_denominator(rsp_reduced_denominator),
      .rsp_last               (rsp_last)
   );

   always #5 clock = ~clock;

   // Offer one fraction pair, after a random gap when the sender idles, and hold it until the transfer
   task automatic send_fractions(input logic [OPERAND_W-1:0] na, input logic [OPERAND_W-1:0] da,
                                 input logic [OPERAND_W-1:0] nb, input logic [OPERAND_W-1:0] db);
      int gap;
      gap = sender_idles ? $urandom_range(0, 16) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_num_a <= na;
      req_den_a <= da;
      req_num_b <= nb;
      req_den_b <= db;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Mostly full-range values, with small ones, near-top ones and rare zeros mixed in
   function automatic logic [OPERAND_W-1:0] pick_operand();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return '0;
      if (r < 35) return OPERAND_W'($urandom_range(1, 16));
      if (r < 42) return OPERAND_W'(16'hFFFF - $urandom_range(0, 3));
      return OPERAND_W'($urandom_range(1, 65535));
   endfunction

   // Numerator that is an exact multiple of the denominator
   function automatic logic [OPERAND_W-1:0] multiple_of(logic [OPERAND_W-1:0] den);
      int k;
      if (den == 0) return '0;
      k = $urandom_range(0, 65535 / den);
      return OPERAND_W'(k * den);
   endfunction

   // Receiver: random hold-off per result while receiver_idles is set, plus one long hold-off on request
   initial begin : receiver
      int wait_cycles;
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end
         wait_cycles = receiver_idles ? $urandom_range(0, 16) : 0;
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Transfer monitor: inputs feed the predictor, results go to the checker
   always @(posedge clock) begin
      fraction_result_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            checker_h.note_request(req_num_a, req_den_a, req_num_b, req_den_b);
         if (rsp_valid && rsp_ready) begin
            got.which_fraction      = rsp_which_fraction;
            got.form                = rsp_form;
            got.whole_part          = rsp_whole_part;
            got.rest_numerator      = rsp_rest_numerator;
            got.reduced_denominator = rsp_reduced_denominator;
            got.last                = rsp_last;
            checker_h.check_result(got);
         end
      end
   end

   // Watchdog on cycles without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("fraction_add_and_reduce_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [OPERAND_W-1:0] na, da, nb, db;
      int burst;
      checker_h = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, integer/proper/mixed forms, zero numerator and denominator
      send_fractions(16'd1, 16'd1, 16'd1, 16'd1);
      send_fractions(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
      send_fractions(16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
      send_fractions(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
      send_fractions(16'hFFFF, 16'd2, 16'hFFFE, 16'hFFFF);
      send_fractions(16'd3, 16'd4, 16'd1, 16'd4);
      send_fractions(16'd6, 16'd4, 16'd10, 16'd6);
      send_fractions(16'd0, 16'd5, 16'd3, 16'd7);
      send_fractions(16'd5, 16'd0, 16'd3, 16'd7);
      send_fractions(16'd0, 16'd0, 16'd0, 16'd0);
      send_fractions(16'd1, 16'd2, 16'd1, 16'd3);
      send_fractions(16'd7, 16'hFFFF, 16'hFFFE, 16'd65521);
      send_fractions(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
      send_fractions(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF);
      send_fractions(16'd2, 16'd4, 16'd9, 16'd0);
      send_fractions(16'd46368, 16'd28657, 16'd28657, 16'd17711);
      send_fractions(16'd3, 16'd1, 16'd5, 16'd7);
      send_fractions(16'd0, 16'hFFFF, 16'd0, 16'd1);
      send_fractions(16'h8000, 16'h0001, 16'h0001, 16'h8000);

      // random pairs in phases with and without idling; one long output hold-off
      burst = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sender_idles   = ((i / 30) % 2) == 0;
         receiver_idles = ((i / 45) % 2) == 0;
         if (i == 70) begin
            hold_requested = 1'b1;
            burst = 8;
         end
         if (burst > 0) begin
            sender_idles = 1'b0;
            burst--;
         end
         da = pick_operand();
         db = pick_operand();
         na = ($urandom_range(0, 99) < 15) ? multiple_of(da) : pick_operand();
         nb = ($urandom_range(0, 99) < 15) ? multiple_of(db) : pick_operand();
         send_fractions(na, da, nb, db);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then watch a while for stray results
      while (checker_h.expected_fractions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d fraction pairs (directed extremes, zero terms, random mix)",
               checker_h.pairs_noted);
      $display("and %0d results under random and long output stalls; %0d mismatches.",
               checker_h.results_checked, checker_h.mismatches);
      if (checker_h.mismatches == 0 && checker_h.expected_fractions.size() == 0) begin
         $display("fraction_add_and_reduce_unit regression: pass");
      end else begin
         $display("fraction_add_and_reduce_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/fara_pkg.sv
hw/rtl/fara_divider.sv
hw/rtl/fara_datapath.sv
hw/rtl/fara_controller.sv
hw/rtl/fraction_add_and_reduce_unit.sv
hw/rtl/fara_checker.sv
test/tb_fraction_add_and_reduce_unit.sv
